@@ rtl/rtsl_pkg.sv @@
// ---------------------------------------------------------------------------
// rtsl_pkg
// Shared constants, pipeline word type and arctangent table for the
// RGB to TSL converter.
// ---------------------------------------------------------------------------
package rtsl_pkg;

  // output fraction bits of tint and saturation
  localparam int OUT_FRAC_BITS = 16;

  // CORDIC vectoring
  localparam int CORDIC_STEPS = 32;
  localparam int VEC_SCALE    = 48;
  localparam int XY_W         = 62;
  localparam int Z_W          = 36;
  localparam longint QUARTER_TURN = 64'd1073741824;

  // chroma difference and its square sums
  localparam int CHR_W = 11;
  localparam int TOP_W = 20;
  localparam int DEN_W = 22;

  // restoring divide top / den, one quotient bit per step
  localparam int DIV_STEPS = 2 * OUT_FRAC_BITS + 2;
  localparam int REM_W     = DEN_W + 1;
  localparam int Q_W       = DIV_STEPS;

  // integer square root, one result bit per step
  localparam int ROOT_W = OUT_FRAC_BITS + 1;
  localparam int SREM_W = ROOT_W + 3;

  // lightness: (32*lsum + 62) / 125 by reciprocal multiply,
  // exact for every numerator below 2^23
  localparam int LNUM_W      = 23;
  localparam int LQ_W        = 16;
  localparam int LIGHT_RECIP = 8589935;   // ceil(2^30 / 125)
  localparam int LIGHT_SH    = 30;
  localparam int LPROD_W     = 47;

  // total number of iterative pipeline steps
  localparam int NUM_STEPS = DIV_STEPS + ROOT_W;

  // output field widths
  localparam int TINT_W  = 16;
  localparam int SAT_W   = 17;
  localparam int LIGHT_W = 16;

  typedef struct packed {
    logic                     black;
    logic                     sat_one;
    logic                     cb_zero;
    logic                     cb_neg;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic [DEN_W-1:0]         den;
    logic [REM_W-1:0]         drem;
    logic [Q_W-1:0]           q;
    logic [ROOT_W-1:0]        root;
    logic [SREM_W-1:0]        srem;
    logic [LNUM_W-1:0]        lnum;
    logic [LQ_W-1:0]          lq;
  } pipe_t;

  // atan(2^-i) / (2*pi) in units of 2^-32 turn
  function automatic logic [Z_W-1:0] atan_turn(input int i);
    logic [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(536870912);
      1:  v = Z_W'(316933406);
      2:  v = Z_W'(167458907);
      3:  v = Z_W'(85004756);
      4:  v = Z_W'(42667331);
      5:  v = Z_W'(21354465);
      6:  v = Z_W'(10679838);
      7:  v = Z_W'(5340245);
      8:  v = Z_W'(2670163);
      9:  v = Z_W'(1335087);
      10: v = Z_W'(667544);
      11: v = Z_W'(333772);
      12: v = Z_W'(166886);
      13: v = Z_W'(83443);
      14: v = Z_W'(41722);
      15: v = Z_W'(20861);
      16: v = Z_W'(10430);
      17: v = Z_W'(5215);
      18: v = Z_W'(2608);
      19: v = Z_W'(1304);
      20: v = Z_W'(652);
      21: v = Z_W'(326);
      22: v = Z_W'(163);
      23: v = Z_W'(81);
      24: v = Z_W'(41);
      25: v = Z_W'(20);
      26: v = Z_W'(10);
      27: v = Z_W'(5);
      28: v = Z_W'(3);
      29: v = Z_W'(1);
      30: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rtsl_step.sv @@
// ---------------------------------------------------------------------------
// rtsl_step
// One pipeline stage: one CORDIC rotation, one divider quotient bit and one
// square-root result bit as STEP selects; the first stage also forms the
// lightness quotient by a reciprocal multiply.
// ---------------------------------------------------------------------------
module rtsl_step #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  rtsl_pkg::pipe_t in_d,
  output logic           out_valid,
  output rtsl_pkg::pipe_t out_d
);
  import rtsl_pkg::*;

  localparam int SQ_I = (STEP >= DIV_STEPS && STEP < NUM_STEPS) ?
                        ROOT_W - 1 - (STEP - DIV_STEPS) : 0;
  localparam int SH   = (STEP < CORDIC_STEPS) ? STEP : 0;

  pipe_t d;

  always_comb begin
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic [REM_W-1:0]       sh;
    logic [SREM_W-1:0]      rm;
    logic [SREM_W-1:0]      trial;
    logic [LPROD_W-1:0]     lprod;
    d  = in_d;
    dx = in_d.y >>> SH;
    dy = in_d.x >>> SH;
    sh = {in_d.drem[REM_W-2:0], 1'b0};
    rm = {in_d.srem[SREM_W-3:0], in_d.q[2*SQ_I +: 2]};
    trial = SREM_W'({in_d.root, 2'b01});
    lprod = '0;

    // CORDIC vectoring rotation
    if (STEP < CORDIC_STEPS) begin
      if (!in_d.y[XY_W-1]) begin
        d.x = in_d.x + dx;
        d.y = in_d.y - dy;
        d.z = in_d.z + $signed(atan_turn(STEP));
      end else begin
        d.x = in_d.x - dx;
        d.y = in_d.y + dy;
        d.z = in_d.z - $signed(atan_turn(STEP));
      end
    end

    // restoring divide
    if (STEP < DIV_STEPS) begin
      if (sh >= {1'b0, in_d.den}) begin
        d.drem = sh - {1'b0, in_d.den};
        d.q    = {in_d.q[Q_W-2:0], 1'b1};
      end else begin
        d.drem = sh;
        d.q    = {in_d.q[Q_W-2:0], 1'b0};
      end
    end

    // square root of the quotient, two bits in per step
    if (STEP >= DIV_STEPS && STEP < NUM_STEPS) begin
      if (rm >= trial) begin
        d.srem = rm - trial;
        d.root = {in_d.root[ROOT_W-2:0], 1'b1};
      end else begin
        d.srem = rm;
        d.root = {in_d.root[ROOT_W-2:0], 1'b0};
      end
    end

    // lightness divide by 125 as a reciprocal multiply
    if (STEP == 0) begin
      lprod = LPROD_W'(in_d.lnum) * LPROD_W'(LIGHT_RECIP);
      d.lq  = lprod[LIGHT_SH +: LQ_W];
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d;
    end
  end

endmodule

@@ rtl/rgb_to_tsl_color_convert_core.sv @@
// ---------------------------------------------------------------------------
// rgb_to_tsl_color_convert_core
// RGB pixel to tint, saturation and lightness, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one RGB pixel per word, red in the low byte.
//   Output stream m_*: tint (Q0.16), saturation (Q1.16), lightness (Q8.8)
//   in tdata, black-pixel flag in tuser.
//   Throughput: one word per clock while the output is not stalled. Every stage holds one pixel.
//   Pipeline from input accept to output valid: one prep stage,
//   51 iterative stages (32 CORDIC rotations run beside the 34-bit
//   restoring divide, then 17 square-root steps) and the output register.
//   The divide and root chain sets that depth.
//   Stall: all stages advance together; when the output word is held
//   (m_tvalid high, m_tready low) the whole pipe freezes and s_tready
//   drops, so nothing is lost or repeated.
//   Reset: rst clears every stage valid bit; the pipe comes up empty.
//   A black pixel (R+G+B = 0) gives zero tint and saturation and sets tuser.
// ---------------------------------------------------------------------------
module rgb_to_tsl_color_convert_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // tint[15:0], saturation[32:16], lightness[48:33]
  output logic        m_tuser    // black_pixel
);
  import rtsl_pkg::*;

  logic en;
  pipe_t prep;
  pipe_t p_d [0:NUM_STEPS];
  logic [NUM_STEPS:0] p_valid;

  // pipe advances unless the output word is stalled
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // prep: sums, chroma differences, squares, CORDIC seed, lightness numerator
  always_comb begin
    logic [7:0]              r;
    logic [7:0]              g;
    logic [7:0]              b;
    logic [9:0]              s;
    logic signed [CHR_W-1:0] ca;
    logic signed [CHR_W-1:0] cb;
    logic [CHR_W-1:0]        cb_abs;
    logic [TOP_W-1:0]        top;
    logic [19:0]             s2;
    logic [17:0]             lsum;
    r  = s_tdata[7:0];
    g  = s_tdata[15:8];
    b  = s_tdata[23:16];
    s  = 10'(r) + 10'(g) + 10'(b);
    ca = CHR_W'(2 * $signed({3'b0, r}) - $signed({3'b0, g}) - $signed({3'b0, b}));
    cb = CHR_W'(2 * $signed({3'b0, g}) - $signed({3'b0, r}) - $signed({3'b0, b}));
    cb_abs = cb[CHR_W-1] ? CHR_W'(-cb) : CHR_W'(cb);
    top = TOP_W'(ca * ca) + TOP_W'(cb * cb);
    s2  = s * s;
    lsum = 18'(18'd299 * r) + 18'(18'd587 * g) + 18'(18'd114 * b);

    prep         = '0;
    prep.black   = (s == '0);
    prep.cb_zero = (cb == '0);
    prep.cb_neg  = cb[CHR_W-1];
    prep.x = {{(XY_W-CHR_W-VEC_SCALE){1'b0}}, cb_abs, {VEC_SCALE{1'b0}}};
    prep.y = {{(XY_W-CHR_W-VEC_SCALE){ca[CHR_W-1]}}, ca, {VEC_SCALE{1'b0}}};
    prep.den     = DEN_W'(s2 * 3'd5);
    prep.sat_one = {{(DEN_W-TOP_W){1'b0}}, top} >= DEN_W'(s2 * 3'd5);
    prep.drem    = REM_W'(top);
    // (256*lsum + 500) / 1000 reduces to (32*lsum + 62) / 125
    prep.lnum    = {lsum, 5'd0} + LNUM_W'(62);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid[0] <= 1'b0;
    end else if (en) begin
      p_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d[0] <= prep;
    end
  end

  // iterative stages
  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    rtsl_step #(.STEP(k)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (p_valid[k]),
      .in_d      (p_d[k]),
      .out_valid (p_valid[k+1]),
      .out_d     (p_d[k+1])
    );
  end

  // output formatting: tint rounding and clamps, saturation rounding, clamp and select
  logic [TINT_W-1:0]  tint;
  logic [SAT_W-1:0]   sat;
  always_comb begin
    pipe_t             f;
    logic signed [Z_W-1:0] t32;
    logic [Z_W-1:0]    tr;
    logic [ROOT_W:0]   rt;
    f   = p_d[NUM_STEPS];
    t32 = f.cb_neg ? Z_W'(3 * QUARTER_TURN) - f.z : Z_W'(QUARTER_TURN) + f.z;
    if (t32[Z_W-1]) begin
      t32 = '0;
    end
    tr = (Z_W'(t32) + Z_W'(1 << (31 - OUT_FRAC_BITS))) >> (32 - OUT_FRAC_BITS);
    if (tr > Z_W'((1 << OUT_FRAC_BITS) - 1)) begin
      tint = TINT_W'((1 << OUT_FRAC_BITS) - 1);
    end else begin
      tint = TINT_W'(tr);
    end
    if (f.black || f.cb_zero) begin
      tint = '0;
    end
    rt = ((ROOT_W+1)'(f.root) + 1'b1) >> 1;
    if (rt > (ROOT_W+1)'(1 << OUT_FRAC_BITS)) begin
      rt = (ROOT_W+1)'(1 << OUT_FRAC_BITS);
    end
    if (f.black) begin
      sat = '0;
    end else if (f.sat_one) begin
      sat = SAT_W'(1 << OUT_FRAC_BITS);
    end else begin
      sat = SAT_W'(rt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p_valid[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, p_d[NUM_STEPS].lq, sat, tint};
      m_tuser <= p_d[NUM_STEPS].black;
    end
  end

  // checks
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[32:0] == '0)
    else $error("black pixel with nonzero tint or saturation");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[32:16] <= 17'd65536)
    else $error("saturation above 1.0");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
